// ----- src/blmr_pkg.sv -----
package blmr_pkg;

	// Panel geometry
	localparam int DISPLAY_WIDTH  = 32;
	localparam int DISPLAY_HEIGHT = 8;
	localparam int CHIPS          = (DISPLAY_WIDTH + 7) / 8;
	localparam int PLANE_BYTES    = CHIPS * DISPLAY_HEIGHT;
	localparam int NUM_PLANES     = 4;

	// Frame store: one entry per (bank, row, chip) holding all four plane bytes
	localparam int MEM_DEPTH = 2 * PLANE_BYTES;
	localparam int ENTRY_W   = NUM_PLANES * 8;
	localparam int IDX_W     = $clog2(PLANE_BYTES);
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CHIP_W    = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam int ROW_W     = 3;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_CLEAR = 3'd1,
		OP_SWAP  = 3'd2,
		OP_TICK  = 3'd3,
		OP_BCAST = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [4:0]  column;
		logic [2:0]  row;
		logic [3:0]  shade;
		logic [15:0] command_word;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CLEAR,
		ST_TICK,
		ST_BCAST
	} state_t;

endpackage

// ----- src/bitplane_led_matrix_refresher.sv -----
// Bit-plane LED matrix refresher.
// Input channel (s_*): one item per command. s_tuser carries the kind: put pixel,
// clear drawing bank, swap banks, refresh tick, broadcast. s_tdata carries column,
// row, shade and the broadcast command word. Unused kinds and pixels off the panel
// are dropped on entry.
// Output channel (m_*): 16-bit driver words. m_tuser marks the first word of a
// group of one word per chip (chip select pulse), m_tlast the final word of an item.
// A refresh tick gives one word per chip and row of the current plane, read from
// the shown bank, and then moves on to the next plane. A broadcast gives one word
// per chip. The other kinds give no words.
// Timing: a tick streams its words one per cycle from the store read port while the
// receiver does not stall, after the item has passed the front register, the queue
// and the sequencer; a broadcast streams one word per cycle under the same condition;
// put pixel reads and then writes one entry, waiting before the read while an output
// word still waits; a clear writes one entry (all four planes) per cycle over the whole
// drawing bank. Items are taken into a two-entry queue behind one front register, so
// up to three items can be accepted ahead of the one being executed.
// Reset empties the queue and then clears both banks, 2 x PLANE_BYTES cycles,
// during which s_tready is low. A stalled receiver holds the output word and
// stops the sequencer; the queue fills and then s_tready drops.
module bitplane_led_matrix_refresher import blmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // column[4:0], row[7:5], shade[11:8], command_word[27:12]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // driver_word[15:0]
	output logic        m_tuser,  // group_start
	output logic        m_tlast
);

	logic init_busy;
	logic push;
	cmd_t push_cmd;
	logic q_ready;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	blmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_busy (init_busy),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_ready   (q_ready)
	);

	blmr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_ready  (q_ready),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	blmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- src/blmr_front.sv -----
module blmr_front import blmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // column[4:0], row[7:5], shade[11:8], command_word[27:12]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	input  logic        init_busy,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        q_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec_cmd;
	logic keep;

	// Unpack and classify the incoming item; drop unused kinds and off-panel pixels
	always_comb begin
		dec_cmd.op           = op_t'(s_tuser);
		dec_cmd.column       = s_tdata[4:0];
		dec_cmd.row          = s_tdata[7:5];
		dec_cmd.shade        = s_tdata[11:8];
		dec_cmd.command_word = s_tdata[27:12];
		keep                 = 1'b0;
		unique case (dec_cmd.op) inside
			OP_PIXEL: keep = (int'(dec_cmd.column) < DISPLAY_WIDTH);
			OP_CLEAR, OP_SWAP, OP_TICK, OP_BCAST: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	// Hold off during the store clearing pass and while the stage is blocked
	assign s_tready = !init_busy && (!valid_s1 || q_ready);
	assign push     = valid_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= keep;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= dec_cmd;
		end
	end

endmodule

// ----- src/blmr_queue.sv -----
module blmr_queue import blmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic q_ready,
	input  logic pop,
	output logic q_valid,
	output cmd_t q_cmd
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];
	assign do_push = push && q_ready;
	assign do_pop  = pop && q_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- src/blmr_back.sv -----
module blmr_back import blmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        init_busy,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	state_t state_q, state_d;

	logic              shown_q;
	logic [1:0]        phase_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CHIP_W-1:0] chip_q;
	logic [ROW_W-1:0]  row_q;
	logic              sweep_bank_q;
	logic [1:0]        plane_q;
	logic [ADDR_W-1:0] pix_addr_q;
	logic [2:0]        pix_bit_q;
	logic [3:0]        pix_shade_q;
	logic [15:0]       cmd_word_q;

	logic [ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic              out_valid_q;
	logic              out_cmd_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_gs_q;
	logic              out_last_q;
	logic [1:0]        out_plane_q;
	logic [15:0]       out_word_q;

	logic               out_free;
	logic               issue;
	logic               re;
	logic               we;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] pix_merged;
	logic               idx_last;
	logic               chip_last;
	logic [ADDR_W-1:0]  shown_base;
	logic [ADDR_W-1:0]  draw_base;
	logic [ADDR_W-1:0]  sweep_base;
	logic [7:0]         plane_byte;

	assign idx_last   = (idx_q == IDX_W'(PLANE_BYTES - 1));
	assign chip_last  = (chip_q == CHIP_W'(CHIPS - 1));
	assign shown_base = shown_q ? ADDR_W'(PLANE_BYTES) : '0;
	assign draw_base  = shown_q ? '0 : ADDR_W'(PLANE_BYTES);
	assign sweep_base = sweep_bank_q ? ADDR_W'(PLANE_BYTES) : '0;
	assign out_free   = !out_valid_q || m_tready;
	assign init_busy  = (state_q == ST_INIT);

	// Set the pixel bit in each of the four plane bytes of the entry
	always_comb begin
		pix_merged = rd_q;
		for (int k = 0; k < NUM_PLANES; k++) begin
			pix_merged[8 * k + int'(pix_bit_q)] = pix_shade_q[k];
		end
	end

	// Sequencer: next state, memory port and output strobes
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		issue   = 1'b0;
		re      = 1'b0;
		we      = 1'b0;
		raddr   = pix_addr_q;
		waddr   = pix_addr_q;
		wdata   = '0;
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = sweep_base + ADDR_W'(idx_q);
				if (idx_last && sweep_bank_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						OP_PIXEL: state_d = ST_PIX_RD;
						OP_CLEAR: state_d = ST_CLEAR;
						OP_SWAP:  state_d = ST_IDLE;
						OP_TICK:  state_d = ST_TICK;
						OP_BCAST: state_d = ST_BCAST;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_PIX_RD: begin
				// rd_q doubles as output data, so wait for the output to drain
				if (!out_valid_q) begin
					re      = 1'b1;
					state_d = ST_PIX_WR;
				end
			end
			ST_PIX_WR: begin
				we      = 1'b1;
				wdata   = pix_merged;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = draw_base + ADDR_W'(idx_q);
				if (idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (out_free) begin
					issue = 1'b1;
					re    = 1'b1;
					raddr = shown_base + ADDR_W'(idx_q);
					if (idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BCAST: begin
				if (out_free) begin
					issue = 1'b1;
					if (chip_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			shown_q      <= 1'b0;
			phase_q      <= '0;
			idx_q        <= '0;
			chip_q       <= '0;
			row_q        <= '0;
			sweep_bank_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_INIT: begin
					if (idx_last) begin
						idx_q        <= '0;
						sweep_bank_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						idx_q  <= '0;
						chip_q <= '0;
						row_q  <= '0;
						if (q_cmd.op == OP_SWAP) begin
							shown_q <= ~shown_q;
						end
						if (q_cmd.op == OP_TICK) begin
							phase_q <= phase_q + 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_TICK: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
						if (chip_last) begin
							chip_q <= '0;
							row_q  <= row_q + 1'b1;
						end else begin
							chip_q <= chip_q + 1'b1;
						end
					end
				end
				ST_BCAST: begin
					if (issue) begin
						chip_q <= chip_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the operands of a command and the fields of each issued word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			plane_q     <= phase_q;
			pix_addr_q  <= draw_base + ADDR_W'(q_cmd.row) * ADDR_W'(CHIPS)
			               + ADDR_W'(q_cmd.column >> 3);
			pix_bit_q   <= ~q_cmd.column[2:0];
			pix_shade_q <= q_cmd.shade;
			cmd_word_q  <= q_cmd.command_word;
		end
		if (issue) begin
			out_cmd_q   <= (state_q == ST_BCAST);
			out_row_q   <= row_q;
			out_gs_q    <= (chip_q == '0);
			out_last_q  <= (state_q == ST_BCAST) ? chip_last : idx_last;
			out_plane_q <= plane_q;
			out_word_q  <= cmd_word_q;
		end
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Phase 0 reads the top byte (shade bit 3), phase 3 the bottom byte (shade bit 0)
	assign plane_byte = rd_q[{~out_plane_q, 3'b000} +: 8];
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_cmd_q ? out_word_q : {8'(out_row_q) + 8'd1, plane_byte};
	assign m_tuser    = out_gs_q;
	assign m_tlast    = out_last_q;

endmodule

// ----- src/blmr_checker.sv -----
module blmr_checker import blmr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item withdrawn while stalled");

	// A stalled word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// Nothing is offered straight out of reset, the store is still being cleared
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid && !s_tready)
		else $error("activity right after reset");

	// A group start and a final word coincide only on a single-chip chain
	a_group_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> (CHIPS == 1))
		else $error("group start on the final word");

endmodule

bind bitplane_led_matrix_refresher blmr_checker u_blmr_checker (.*);
